// ===== hw/rtl/stq_pkg.sv =====
// Shared types and constants of the sorted timer event queue.
package stq_pkg;

   localparam int TIME_W   = 32;
   localparam int CLIENT_W = 11;

   localparam logic [CLIENT_W-1:0] CLIENT_DETACHED = 11'h7FE;  // -2
   localparam logic [TIME_W-1:0]   TIMEOUT_EMPTY   = 32'hFFFF_FFFF;  // -1
   localparam logic [TIME_W-1:0]   TIMEOUT_MAX     = 32'h7FFF_FFFF;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_POP    = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_QUERY  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_POP_EMPTY  = 2'd1,
      ST_INSERT_FULL = 2'd2,
      ST_UNUSED     = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_INS_RD,
      S_INS_CHK,
      S_REM_RD,
      S_REM_CHK,
      S_HEAD_RD,
      S_HEAD_CHK,
      S_EMIT
   } state_type;

   // Result word fields other than the tag and the count.
   typedef struct packed {
      status_type          status;
      logic [TIME_W-1:0]   out_time;
      logic [CLIENT_W-1:0] out_client;
      logic [TIME_W-1:0]   timeout_ms;
   } res_type;

endpackage

// ===== hw/rtl/stq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module stq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/stq_ctrl.sv =====
// Sequencer of the queue: ring addressing, sorted insert walk, client sweep.
module stq_ctrl #(
   parameter int DEPTH    = 64,
   parameter int TAG_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_command,
   input  logic [stq_pkg::TIME_W-1:0]    req_exec_time,
   input  logic [stq_pkg::CLIENT_W-1:0]  req_client_index,
   input  logic [TAG_BITS-1:0]           req_tag,
   input  logic [stq_pkg::TIME_W-1:0]    req_now_time,
   input  logic                          out_free,
   output logic                          done,
   output stq_pkg::res_type              res,
   output logic [TAG_BITS-1:0]           res_tag,
   output logic [$clog2(DEPTH+1)-1:0]    res_count
);
   import stq_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int WW = TIME_W + CLIENT_W + TAG_BITS;
   localparam logic [AW:0] DEPTH_W = (AW + 1)'(DEPTH);

   state_type             state_ff, state_in;
   cmd_type               cmd_ff, cmd_in;
   logic [TIME_W-1:0]     time_ff, time_in;
   logic [CLIENT_W-1:0]   client_ff, client_in;
   logic [TAG_BITS-1:0]   tag_ff, tag_in;
   logic [TIME_W-1:0]     now_ff, now_in;
   logic [CW-1:0]         pos_ff, pos_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [AW-1:0]         head_ff, head_in;
   res_type               res_ff, res_in;
   logic [TAG_BITS-1:0]   res_tag_ff, res_tag_in;

   logic                  wr_en, rd_en;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic [WW-1:0]         wr_data, rd_data;
   logic [TIME_W-1:0]     rd_time;
   logic [CLIENT_W-1:0]   rd_client;
   logic [TAG_BITS-1:0]   rd_tag;
   logic [TIME_W:0]       diff;

   // map a logical position to a ring address
   function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                          input logic [CW-1:0] lpos);
      logic [AW:0] sum;
      sum = (AW + 1)'(head) + (AW + 1)'(lpos);
      if (sum >= DEPTH_W) begin
         sum = sum - DEPTH_W;
      end
      return sum[AW-1:0];
   endfunction

   stq_ram #(.WIDTH(WW), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign {rd_time, rd_client, rd_tag} = rd_data;
   assign diff = {1'b0, rd_time} - {1'b0, now_ff};

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         head_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         head_ff  <= head_in;
      end
   end

   // held request word, walk position and pending result
   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      time_ff    <= time_in;
      client_ff  <= client_in;
      tag_ff     <= tag_in;
      now_ff     <= now_in;
      pos_ff     <= pos_in;
      res_ff     <= res_in;
      res_tag_ff <= res_tag_in;
   end

   // next state, memory accesses and result
   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      time_in    = time_ff;
      client_in  = client_ff;
      tag_in     = tag_ff;
      now_in     = now_ff;
      pos_in     = pos_ff;
      count_in   = count_ff;
      head_in    = head_ff;
      res_in     = res_ff;
      res_tag_in = res_tag_ff;
      wr_en      = 1'b0;
      wr_addr    = phys(head_ff, pos_ff);
      wr_data    = {time_ff, client_ff, tag_ff};
      rd_en      = 1'b0;
      rd_addr    = head_ff;
      done       = 1'b0;
      req_ready  = (state_ff == S_IDLE);

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in     = cmd_type'(req_command);
               time_in    = req_exec_time;
               client_in  = req_client_index;
               tag_in     = req_tag;
               now_in     = req_now_time;
               res_in     = '0;
               res_tag_in = '0;
               unique case (cmd_type'(req_command))
                  CMD_INSERT: begin
                     pos_in = count_ff;
                     if (count_ff == CW'(DEPTH)) begin
                        res_in.status = ST_INSERT_FULL;
                        state_in      = S_EMIT;
                     end else begin
                        state_in = S_INS_RD;
                     end
                  end
                  CMD_POP: begin
                     if (count_ff == '0) begin
                        res_in.status = ST_POP_EMPTY;
                        state_in      = S_EMIT;
                     end else begin
                        state_in = S_HEAD_RD;
                     end
                  end
                  CMD_REMOVE: begin
                     pos_in   = '0;
                     state_in = S_REM_RD;
                  end
                  CMD_QUERY: begin
                     if (count_ff == '0) begin
                        res_in.timeout_ms = TIMEOUT_EMPTY;
                        state_in          = S_EMIT;
                     end else begin
                        state_in = S_HEAD_RD;
                     end
                  end
               endcase
            end
         end
         // read the neighbor below the hole, or drop the new entry in
         S_INS_RD: begin
            if (pos_ff == '0) begin
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
               state_in = S_EMIT;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = phys(head_ff, pos_ff - 1'b1);
               state_in = S_INS_CHK;
            end
         end
         // shift a later entry up, or place the new one after it
         S_INS_CHK: begin
            wr_en = 1'b1;
            if (rd_time > time_ff) begin
               wr_data  = rd_data;
               pos_in   = pos_ff - 1'b1;
               state_in = S_INS_RD;
            end else begin
               count_in = count_ff + 1'b1;
               state_in = S_EMIT;
            end
         end
         S_REM_RD: begin
            if (pos_ff == count_ff) begin
               state_in = S_EMIT;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = phys(head_ff, pos_ff);
               state_in = S_REM_CHK;
            end
         end
         // detach the client or move higher client numbers down
         S_REM_CHK: begin
            wr_en = 1'b1;
            if (rd_client == client_ff) begin
               wr_data = {rd_time, CLIENT_DETACHED, rd_tag};
            end else if ($signed(rd_client) > $signed(client_ff)) begin
               wr_data = {rd_time, rd_client - 1'b1, rd_tag};
            end else begin
               wr_data = rd_data;
            end
            pos_in   = pos_ff + 1'b1;
            state_in = S_REM_RD;
         end
         S_HEAD_RD: begin
            rd_en    = 1'b1;
            rd_addr  = head_ff;
            state_in = S_HEAD_CHK;
         end
         S_HEAD_CHK: begin
            if (cmd_ff == CMD_POP) begin
               res_in.out_time   = rd_time;
               res_in.out_client = rd_client;
               res_tag_in        = rd_tag;
               head_in           = phys(head_ff, CW'(1));
               count_in          = count_ff - 1'b1;
            end else if (rd_time <= now_ff) begin
               res_in.timeout_ms = '0;
            end else if (diff[TIME_W-1]) begin
               res_in.timeout_ms = TIMEOUT_MAX;
            end else begin
               res_in.timeout_ms = diff[TIME_W-1:0];
            end
            state_in = S_EMIT;
         end
         // hand the result over once the output register is free
         S_EMIT: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign res       = res_ff;
   assign res_tag   = res_tag_ff;
   assign res_count = count_ff;

endmodule

// ===== hw/rtl/sorted_timer_event_queue_unit.sv =====
// Top level of the sorted timer event queue with its result register.
//
// A queue of up to DEPTH pending actions kept sorted by due time (ms).
// The req_ channel takes one command word: insert, pop earliest, remove
// client or query timeout. Each command gives exactly one word on the
// rsp_ channel with a status, the popped entry, the timeout and the
// number of entries afterwards.
// Entries live in one RAM used as a ring from a head pointer, so a pop
// only advances the head. An insert walks down from the tail, moving each
// later entry up with a read, then a compare and write; remove-client
// sweeps every entry the same way. Pop and query read the head entry; a
// full insert, or a pop or query on an empty queue, emits its result
// with no RAM access. A new command is taken only when the last is done.
// Reset empties the queue at once; RAM contents are not cleared.
// A stalled rsp_ready holds the result in its register; the next command
// may be accepted meanwhile and waits to emit its own result.
module sorted_timer_event_queue_unit #(
   parameter int DEPTH    = 64,
   parameter int TAG_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_command,
   input  logic [stq_pkg::TIME_W-1:0]    req_exec_time,
   input  logic [stq_pkg::CLIENT_W-1:0]  req_client_index,
   input  logic [TAG_BITS-1:0]           req_payload,
   input  logic [stq_pkg::TIME_W-1:0]    req_now_time,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_status,
   output logic [stq_pkg::TIME_W-1:0]    rsp_out_time,
   output logic [stq_pkg::CLIENT_W-1:0]  rsp_out_client,
   output logic [TAG_BITS-1:0]           rsp_out_payload,
   output logic [stq_pkg::TIME_W-1:0]    rsp_timeout_ms,
   output logic [$clog2(DEPTH+1)-1:0]    rsp_entry_count
);
   import stq_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   logic                 out_free;
   logic                 done;
   res_type              res;
   logic [TAG_BITS-1:0]  res_tag;
   logic [CW-1:0]        res_count;

   logic                 rsp_valid_ff, rsp_valid_in;
   res_type              rsp_res_ff;
   logic [TAG_BITS-1:0]  rsp_tag_ff;
   logic [CW-1:0]        rsp_count_ff;

   stq_ctrl #(.DEPTH(DEPTH), .TAG_BITS(TAG_BITS)) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_exec_time    (req_exec_time),
      .req_client_index (req_client_index),
      .req_tag          (req_payload),
      .req_now_time     (req_now_time),
      .out_free         (out_free),
      .done             (done),
      .res              (res),
      .res_tag          (res_tag),
      .res_count        (res_count)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // hold the result word until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_res_ff   <= res;
         rsp_tag_ff   <= res_tag;
         rsp_count_ff <= res_count;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_res_ff.status;
   assign rsp_out_time    = rsp_res_ff.out_time;
   assign rsp_out_client  = rsp_res_ff.out_client;
   assign rsp_out_payload = rsp_tag_ff;
   assign rsp_timeout_ms  = rsp_res_ff.timeout_ms;
   assign rsp_entry_count = rsp_count_ff;

endmodule
